// ===== rtl/ppc_pkg.sv =====
// Package for the promotable priority collection.
// Holds sizes, opcode and status codes, and the controller/datapath structs.
// No dependencies.
package ppc_pkg;

  // Table geometry and field widths.
  localparam int unsigned CAPACITY      = 256;
  localparam int unsigned ID_BITS       = $clog2(CAPACITY);
  localparam int unsigned NEXT_BITS     = ID_BITS + 1;
  localparam int unsigned PAYLOAD_BITS  = 32;
  localparam int unsigned PRIORITY_BITS = 16;
  localparam int unsigned OP_BITS       = 3;
  localparam int unsigned STATUS_BITS   = 2;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PROMOTE  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_IS_VALID = 3'd2;
  localparam logic [OP_BITS-1:0] OP_GET      = 3'd3;
  localparam logic [OP_BITS-1:0] OP_GET_MAX  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_POP_MAX  = 3'd5;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BADID = 2'd3;

  // Read address sources for the table memories.
  typedef enum logic [1:0] {
    RD_ID,
    RD_SCAN,
    RD_BEST
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    add_exec;
    logic    lookup_exec;
    logic    scan_start;
    logic    scan_step;
    logic    max_exec;
    logic    out_load;
    rd_sel_e rd_sel;
  } ppc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               scan_last;
  } ppc_sts_t;

endpackage

// ===== rtl/ppc_if.sv =====
// Handshake interfaces for the request and response words.
// Depends on ppc_pkg.
interface ppc_req_if import ppc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_BITS-1:0]      opcode;
  logic [ID_BITS-1:0]      entry_id;
  logic [PAYLOAD_BITS-1:0] payload_in;

  modport source (output valid, output opcode, output entry_id, output payload_in,
                  input ready);
  modport sink   (input valid, input opcode, input entry_id, input payload_in,
                  output ready);
endinterface

interface ppc_rsp_if import ppc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_BITS-1:0]   status;
  logic [ID_BITS-1:0]       result_id;
  logic [PAYLOAD_BITS-1:0]  payload_out;
  logic [PRIORITY_BITS-1:0] priority_out;
  logic                     is_member;

  modport source (output valid, output status, output result_id, output payload_out,
                  output priority_out, output is_member, input ready);
  modport sink   (input valid, input status, input result_id, input payload_out,
                  input priority_out, input is_member, output ready);
endinterface

// ===== rtl/ppc_ctrl.sv =====
// Controller state machine for the promotable priority collection.
// Sequences add, lookup and max-scan operations; depends on ppc_pkg.
module ppc_ctrl import ppc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  ppc_sts_t sts_i,
  output ppc_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_LOOKUP   = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_DRAIN    = 3'd4;
  localparam logic [2:0] S_FETCH    = 3'd5;
  localparam logic [2:0] S_MAX      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || rsp_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_ID;

    // The response word leaves when the sink takes it.
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op == OP_ADD) begin
          cmd_o.add_exec = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.op == OP_GET_MAX || sts_i.op == OP_POP_MAX) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          // Read the addressed entry; data is ready next cycle.
          cmd_o.rd_sel = RD_ID;
          state_d      = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup_exec = 1'b1;
        state_d           = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.rd_sel    = RD_SCAN;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Last compare of the scan happens in this cycle.
        state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.rd_sel = RD_BEST;
        state_d      = S_MAX;
      end
      S_MAX: begin
        cmd_o.max_exec = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and response valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/ppc_dpath.sv =====
// Datapath for the promotable priority collection: table memories, valid
// bits, id counter, max-scan compare and result registers. Depends on ppc_pkg.
module ppc_dpath import ppc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppc_cmd_t                 cmd_i,
  output ppc_sts_t                 sts_o,
  input  logic [OP_BITS-1:0]       opcode_i,
  input  logic [ID_BITS-1:0]       entry_id_i,
  input  logic [PAYLOAD_BITS-1:0]  payload_in_i,
  output logic [STATUS_BITS-1:0]   status_o,
  output logic [ID_BITS-1:0]       result_id_o,
  output logic [PAYLOAD_BITS-1:0]  payload_out_o,
  output logic [PRIORITY_BITS-1:0] priority_out_o,
  output logic                     is_member_o
);

  // Table memories; contents are undefined until written by add.
  logic [PRIORITY_BITS-1:0] prio_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  pay_mem  [CAPACITY];
  logic [CAPACITY-1:0]      valid_q;
  logic [NEXT_BITS-1:0]     next_id_q;

  // Captured request word.
  logic [OP_BITS-1:0]       op_q;
  logic [ID_BITS-1:0]       id_q;
  logic [PAYLOAD_BITS-1:0]  pay_q;

  // Memory ports.
  logic [ID_BITS-1:0]       rd_addr;
  logic [PRIORITY_BITS-1:0] prio_rd_q;
  logic [PAYLOAD_BITS-1:0]  pay_rd_q;
  logic                     prio_we, pay_we;
  logic [ID_BITS-1:0]       wr_addr;
  logic [PRIORITY_BITS-1:0] prio_wdata;

  // Scan state.
  logic [ID_BITS-1:0]       scan_cnt_q;
  logic [ID_BITS-1:0]       scan_idx_q;
  logic                     scan_vld_q;
  logic                     scan_pipe_q;
  logic [ID_BITS-1:0]       best_idx_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;
  logic                     found_q;

  // Result and output registers.
  logic [STATUS_BITS-1:0]   res_status_q;
  logic [ID_BITS-1:0]       res_id_q;
  logic [PAYLOAD_BITS-1:0]  res_pay_q;
  logic [PRIORITY_BITS-1:0] res_prio_q;
  logic                     res_member_q;
  logic [STATUS_BITS-1:0]   out_status_q;
  logic [ID_BITS-1:0]       out_id_q;
  logic [PAYLOAD_BITS-1:0]  out_pay_q;
  logic [PRIORITY_BITS-1:0] out_prio_q;
  logic                     out_member_q;

  logic full;
  logic id_valid;
  logic prio_top;
  logic take_scan;

  assign full      = (next_id_q == NEXT_BITS'(CAPACITY));
  assign id_valid  = valid_q[id_q];
  assign prio_top  = (prio_rd_q == {PRIORITY_BITS{1'b1}});
  assign take_scan = scan_pipe_q && scan_vld_q && (!found_q || prio_rd_q >= best_prio_q);

  assign sts_o.op        = op_q;
  assign sts_o.scan_last = (scan_cnt_q == ID_BITS'(CAPACITY - 1));

  // Read address select.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_ID:   rd_addr = id_q;
      RD_SCAN: rd_addr = scan_cnt_q;
      RD_BEST: rd_addr = best_idx_q;
      default: rd_addr = id_q;
    endcase
  end

  // Write port control: add writes both stores, promote bumps the priority.
  always_comb begin
    pay_we     = cmd_i.add_exec && !full;
    prio_we    = pay_we;
    wr_addr    = next_id_q[ID_BITS-1:0];
    prio_wdata = '0;
    if (cmd_i.lookup_exec && op_q == OP_PROMOTE && id_valid && !prio_top) begin
      prio_we    = 1'b1;
      wr_addr    = id_q;
      prio_wdata = PRIORITY_BITS'(prio_rd_q + 1'b1);
    end
  end

  // Table memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[wr_addr] <= prio_wdata;
    end
    if (pay_we) begin
      pay_mem[wr_addr] <= pay_q;
    end
    prio_rd_q <= prio_mem[rd_addr];
    pay_rd_q  <= pay_mem[rd_addr];
  end

  // Valid bits and id counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      next_id_q <= '0;
    end else begin
      if (cmd_i.add_exec && !full) begin
        valid_q[next_id_q[ID_BITS-1:0]] <= 1'b1;
        next_id_q                       <= NEXT_BITS'(next_id_q + 1'b1);
      end
      if (cmd_i.max_exec && found_q && op_q == OP_POP_MAX) begin
        valid_q[best_idx_q] <= 1'b0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      id_q  <= entry_id_i;
      pay_q <= payload_in_i;
    end
  end

  // Max scan: one entry is read per cycle and compared in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_pipe_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      scan_pipe_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (take_scan) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_cnt_q <= ID_BITS'(scan_cnt_q + 1'b1);
    end
    scan_idx_q <= scan_cnt_q;
    scan_vld_q <= valid_q[scan_cnt_q];
    if (take_scan) begin
      best_idx_q  <= scan_idx_q;
      best_prio_q <= prio_rd_q;
    end
  end

  // Result word, built by the operation's final step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_exec) begin
      res_status_q <= full ? ST_FULL : ST_OK;
      res_id_q     <= full ? '0 : next_id_q[ID_BITS-1:0];
      res_pay_q    <= '0;
      res_prio_q   <= '0;
      res_member_q <= 1'b0;
    end else if (cmd_i.lookup_exec) begin
      res_id_q   <= '0;
      res_prio_q <= '0;
      case (op_q)
        OP_PROMOTE: begin
          res_status_q <= id_valid ? ST_OK : ST_BADID;
          res_pay_q    <= '0;
          res_member_q <= 1'b0;
        end
        OP_IS_VALID: begin
          res_status_q <= ST_OK;
          res_pay_q    <= '0;
          res_member_q <= id_valid;
        end
        OP_GET: begin
          res_status_q <= id_valid ? ST_OK : ST_BADID;
          res_pay_q    <= id_valid ? pay_rd_q : '0;
          res_member_q <= id_valid;
        end
        default: begin
          res_status_q <= ST_OK;
          res_pay_q    <= '0;
          res_member_q <= 1'b0;
        end
      endcase
    end else if (cmd_i.max_exec) begin
      res_member_q <= 1'b0;
      if (found_q) begin
        res_status_q <= ST_OK;
        res_id_q     <= best_idx_q;
        res_pay_q    <= pay_rd_q;
        res_prio_q   <= best_prio_q;
      end else begin
        res_status_q <= ST_EMPTY;
        res_id_q     <= '0;
        res_pay_q    <= '0;
        res_prio_q   <= '0;
      end
    end
  end

  // Output register, loaded when the response slot is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_pay_q    <= res_pay_q;
      out_prio_q   <= res_prio_q;
      out_member_q <= res_member_q;
    end
  end

  assign status_o       = out_status_q;
  assign result_id_o    = out_id_q;
  assign payload_out_o  = out_pay_q;
  assign priority_out_o = out_prio_q;
  assign is_member_o    = out_member_q;

endmodule

// ===== rtl/promotable_priority_collection_top.sv =====
// Promotable priority collection: priority queue with increase-key.
// Add passes through the dispatch and done states; promote/is_valid/get add a lookup state,
// and get_max/pop_max scan all CAPACITY entries, then pass through drain, fetch and max states.
// The scan reads one priority memory entry per cycle. A new word can be accepted once the response is valid.
// Reset clears valid bits, the id counter and the controller; table memories are not cleared.
// Depends on ppc_pkg, ppc_if, ppc_ctrl and ppc_dpath.
module promotable_priority_collection_top import ppc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  ppc_req_if.sink   req_i,
  ppc_rsp_if.source rsp_o
);

  ppc_cmd_t cmd;
  ppc_sts_t sts;

  // Controller.
  ppc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  ppc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (req_i.opcode),
    .entry_id_i     (req_i.entry_id),
    .payload_in_i   (req_i.payload_in),
    .status_o       (rsp_o.status),
    .result_id_o    (rsp_o.result_id),
    .payload_out_o  (rsp_o.payload_out),
    .priority_out_o (rsp_o.priority_out),
    .is_member_o    (rsp_o.is_member)
  );

  // One word in flight: no new word is taken right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while previous word still in flight");

  // A loaded result is presented on the response channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_o.valid)
    else $error("result loaded but response not valid");

  // An empty-table result carries no id and no priority.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_EMPTY |-> rsp_o.result_id == '0 &&
      rsp_o.priority_out == '0)
    else $error("empty status with nonzero id or priority");

endmodule
